// File: design/mqsb_pkg.sv
// Package for the multi-queue symbol buffer.
// Sizes, operation and status codes, payload, entry, request and state types, sym_addr function.
// No dependencies.
package mqsb_pkg;

    localparam int QUEUES = 8;
    localparam int DEPTH  = 16;

    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int DW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(QUEUES * DEPTH);

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_EMPTY   = 2'd2;
    localparam logic [1:0] STAT_INVALID = 2'd3;

    localparam logic [3:0] QUEUES_RESET = 4'd8;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] target_queue;
        logic [7:0] symbol;
    } mqsb_in_t;

    typedef struct packed {
        logic [3:0] queue_id;
        logic [7:0] data_symbol;
        logic [1:0] status;
        logic       last;
    } mqsb_out_t;

    typedef struct packed {
        logic [DW-1:0] head;
        logic [CW-1:0] count;
    } mqsb_entry_t;

    typedef struct packed {
        logic          rd_en;
        logic          wr_en;
        logic [AW-1:0] addr;
        logic [7:0]    wdata;
    } mqsb_sym_req_t;

    typedef struct packed {
        logic          rd_en;
        logic          wr_en;
        logic [QW-1:0] idx;
        mqsb_entry_t   wdata;
    } mqsb_tbl_req_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_EMIT
    } mqsb_state_t;

    function automatic logic [AW-1:0] sym_addr(logic [QW-1:0] q, logic [DW-1:0] idx);
        return AW'(q) * AW'(DEPTH) + AW'(idx);
    endfunction

endpackage

// File: design/mqsb_sym_ram.sv
// Symbol store: one synchronous RAM holding all queues, with a registered read.
// Depends on mqsb_pkg.
module mqsb_sym_ram (
    input  logic                   clk,
    input  mqsb_pkg::mqsb_sym_req_t req,
    output logic [7:0]             rdata
);
    import mqsb_pkg::*;

    logic [7:0] mem [QUEUES*DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/mqsb_qtable.sv
// Queue table: head pointer and fill count per queue in a synchronous RAM.
// Per-queue valid bits make an unwritten entry read as an empty queue.
// Depends on mqsb_pkg.
module mqsb_qtable (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mqsb_pkg::mqsb_tbl_req_t req,
    output mqsb_pkg::mqsb_entry_t   rdata
);
    import mqsb_pkg::*;

    mqsb_entry_t      mem [QUEUES];
    mqsb_entry_t      rdata_reg;
    logic [QUEUES-1:0] valid_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.idx] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.idx] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.idx];
            end
        end
    end

    assign rdata = rd_valid_reg ? rdata_reg : '0;

endmodule

// File: design/mqsb_ctrl.sv
// Sequencer: checks the queue number, reads and updates the queue table,
// moves symbols to and from the store and holds the output register.
// Depends on mqsb_pkg.
module mqsb_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  mqsb_pkg::mqsb_in_t      in_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output mqsb_pkg::mqsb_out_t     out_data,
    input  logic [3:0]              queues_in_use,
    output mqsb_pkg::mqsb_sym_req_t sym_req,
    input  logic [7:0]              sym_rdata,
    output mqsb_pkg::mqsb_tbl_req_t tbl_req,
    input  mqsb_pkg::mqsb_entry_t   tbl_rdata
);
    import mqsb_pkg::*;

    mqsb_state_t   state_reg, state_next;
    mqsb_in_t      item_reg, item_next;
    logic [QW-1:0] q_reg, q_next;
    logic [DW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;
    mqsb_out_t     out_reg, out_next;

    logic          out_free;
    logic          accept;
    logic          qn_valid;
    logic [QW-1:0] in_q;
    logic          is_push;
    logic          full;
    logic          empty;
    logic [DW:0]   tail_sum;
    logic [DW-1:0] tail;
    logic [DW-1:0] head_inc;
    logic [CW-1:0] count_dec;
    logic          last_elem;
    logic          load;
    mqsb_out_t     load_val;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;

    assign qn_valid = (in_data.target_queue != 4'd0)
                   && (in_data.target_queue <= queues_in_use)
                   && (int'(in_data.target_queue) <= QUEUES);
    assign in_q     = QW'(in_data.target_queue - 4'd1);

    assign is_push  = (item_reg.operation == OP_PUSH);
    assign full     = (tbl_rdata.count == CW'(DEPTH));
    assign empty    = (tbl_rdata.count == '0);
    assign tail_sum = (DW+1)'(tbl_rdata.head) + (DW+1)'(tbl_rdata.count);
    assign tail     = (tail_sum >= (DW+1)'(DEPTH)) ? DW'(tail_sum - (DW+1)'(DEPTH))
                                                   : DW'(tail_sum);
    assign head_inc  = (head_reg == DW'(DEPTH - 1)) ? '0 : head_reg + DW'(1);
    assign count_dec = count_reg - CW'(1);
    assign last_elem = (item_reg.operation != OP_DRAIN) || (count_dec == '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && qn_valid)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next = (!is_push && !empty) ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (out_free && last_elem)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_next  = item_reg;
        q_next     = q_reg;
        head_next  = head_reg;
        count_next = count_reg;
        load       = 1'b0;
        load_val   = '{queue_id: item_reg.target_queue, data_symbol: 8'd0,
                       status: STAT_OK, last: 1'b1};
        sym_req    = '{rd_en: 1'b0, wr_en: 1'b0, addr: sym_addr(q_reg, head_reg),
                       wdata: item_reg.symbol};
        tbl_req    = '{rd_en: 1'b0, wr_en: 1'b0, idx: q_reg, wdata: '0};
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next = in_data;
                    q_next    = in_q;
                    if (qn_valid)
                    begin
                        tbl_req.rd_en = 1'b1;
                        tbl_req.idx   = in_q;
                    end
                    else
                    begin
                        load              = 1'b1;
                        load_val.queue_id = in_data.target_queue;
                        load_val.status   = STAT_INVALID;
                    end
                end
            end
            S_LOOKUP:
            begin
                if (out_free)
                begin
                    if (is_push)
                    begin
                        load = 1'b1;
                        if (full)
                        begin
                            load_val.status = STAT_FULL;
                        end
                        else
                        begin
                            sym_req.wr_en       = 1'b1;
                            sym_req.addr        = sym_addr(q_reg, tail);
                            tbl_req.wr_en       = 1'b1;
                            tbl_req.wdata.head  = tbl_rdata.head;
                            tbl_req.wdata.count = tbl_rdata.count + CW'(1);
                        end
                    end
                    else if (empty)
                    begin
                        load            = 1'b1;
                        load_val.status = STAT_EMPTY;
                    end
                    else
                    begin
                        sym_req.rd_en = 1'b1;
                        sym_req.addr  = sym_addr(q_reg, tbl_rdata.head);
                        head_next     = tbl_rdata.head;
                        count_next    = tbl_rdata.count;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    load                 = 1'b1;
                    load_val.data_symbol = sym_rdata;
                    load_val.last        = last_elem;
                    head_next            = head_inc;
                    count_next           = count_dec;
                    if (last_elem)
                    begin
                        tbl_req.wr_en       = 1'b1;
                        tbl_req.wdata.head  = head_inc;
                        tbl_req.wdata.count = count_dec;
                    end
                    else
                    begin
                        sym_req.rd_en = 1'b1;
                        sym_req.addr  = sym_addr(q_reg, head_inc);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid_next = load || (out_valid_reg && out_stall);
    assign out_next       = load ? load_val : out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        q_reg     <= q_next;
        head_reg  <= head_next;
        count_reg <= count_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: design/multi_queue_symbol_buffer.sv
// Multi-queue symbol buffer. An invalid queue number is flagged straight from the idle state;
// push and empty results follow a queue-table read, and pop and drain symbols follow a
// queue-table read and then a symbol RAM read; a drain then emits its symbols back to back
// unless out_stall holds them. A new item is taken only once the last one is finished.
// Reset clears the per-queue valid bits at once (all queues empty) and sets
// queues_in_use to 8; no clearing pass. Depends on mqsb_pkg and the mqsb_* modules.
module multi_queue_symbol_buffer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mqsb_pkg::mqsb_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output mqsb_pkg::mqsb_out_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_data
);
    import mqsb_pkg::*;

    logic [3:0]    queues_in_use_reg;
    mqsb_sym_req_t sym_req;
    logic [7:0]    sym_rdata;
    mqsb_tbl_req_t tbl_req;
    mqsb_entry_t   tbl_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queues_in_use_reg <= QUEUES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            queues_in_use_reg <= cfg_data;
        end
    end

    mqsb_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .queues_in_use (queues_in_use_reg),
        .sym_req       (sym_req),
        .sym_rdata     (sym_rdata),
        .tbl_req       (tbl_req),
        .tbl_rdata     (tbl_rdata)
    );

    mqsb_sym_ram u_sym_ram (
        .clk   (clk),
        .req   (sym_req),
        .rdata (sym_rdata)
    );

    mqsb_qtable u_qtable (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tbl_req),
        .rdata (tbl_rdata)
    );

endmodule

// File: design/mqsb_checker.sv
// Port-level checks for the multi-queue symbol buffer, bound to the top level.
// Depends on mqsb_pkg.
module mqsb_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input mqsb_pkg::mqsb_in_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input mqsb_pkg::mqsb_out_t out_data
);
    import mqsb_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != STAT_OK |-> out_data.last)
        else $error("error result not marked last");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != STAT_OK |-> out_data.data_symbol == 8'd0)
        else $error("error result carries a symbol");

    a_zero_queue: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.target_queue == 4'd0
        |=> out_valid && out_data.status == STAT_INVALID && out_data.queue_id == 4'd0)
        else $error("queue zero not flagged on the next cycle");

endmodule

bind multi_queue_symbol_buffer mqsb_checker u_mqsb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// File: sim/testbench.sv
// Self-checking testbench for multi_queue_symbol_buffer: push, pop and drain traffic
// with random idles, checked against an in-bench model of the queue bank.
// Depends on mqsb_pkg and the design sources.
module testbench;
    import mqsb_pkg::*;

    localparam logic [1:0] OP_POP_ALT  = 2'd3;
    localparam logic [7:0] SYM_A       = "A";
    localparam int         IDLE_PCT    = 13;
    localparam int         HOLD_CYCLES = 300;
    localparam int         TAIL_CYCLES = 20;
    localparam int         CYCLE_LIMIT = 300000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    mqsb_in_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    mqsb_out_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = '0;

    mqsb_in_t    pending_items[$];
    mqsb_out_t   expected_results[$];
    int          items_issued = 0;
    int          items_accepted = 0;
    int          errors = 0;
    int          cycle_count = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    bit          no_idle = 1'b0;

    // model state
    logic [7:0]  symbol_copy[QUEUES][DEPTH];
    int          head_copy[QUEUES];
    int          fill_copy[QUEUES];
    logic [3:0]  queues_limit = QUEUES_RESET;

    multi_queue_symbol_buffer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    task automatic model_queue_op(input mqsb_in_t it);
        int        q;
        int        lim;
        mqsb_out_t r;
        begin
            lim = (int'(queues_limit) < QUEUES) ? int'(queues_limit) : QUEUES;
            r.queue_id    = it.target_queue;
            r.data_symbol = '0;
            r.status      = STAT_OK;
            r.last        = 1'b1;
            if (it.target_queue == 0 || int'(it.target_queue) > lim)
            begin
                r.status = STAT_INVALID;
                expected_results.push_back(r);
            end
            else
            begin
                q = int'(it.target_queue) - 1;
                if (it.operation == OP_PUSH)
                begin
                    if (fill_copy[q] >= DEPTH)
                        r.status = STAT_FULL;
                    else
                    begin
                        symbol_copy[q][(head_copy[q] + fill_copy[q]) % DEPTH] = it.symbol;
                        fill_copy[q]++;
                    end
                    expected_results.push_back(r);
                end
                else if (fill_copy[q] == 0)
                begin
                    r.status = STAT_EMPTY;
                    expected_results.push_back(r);
                end
                else
                begin
                    // drain repeats until empty; pop and the spare code take one
                    do
                    begin
                        r.data_symbol = symbol_copy[q][head_copy[q]];
                        head_copy[q]  = (head_copy[q] + 1) % DEPTH;
                        fill_copy[q]--;
                        r.last = (fill_copy[q] == 0 || it.operation != OP_DRAIN);
                        expected_results.push_back(r);
                    end
                    while (it.operation == OP_DRAIN && fill_copy[q] > 0);
                end
            end
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                model_queue_op(in_data);
                items_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 &&
                    (no_idle || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_items.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, out_data);
                end
                else if (out_data.queue_id    !== expected_results[0].queue_id    ||
                         out_data.data_symbol !== expected_results[0].data_symbol ||
                         out_data.status      !== expected_results[0].status      ||
                         out_data.last        !== expected_results[0].last)
                begin
                    errors++;
                    $display({"%0t: mismatch exp q=%0d d=%h st=%0d last=%b",
                              " got q=%0d d=%h st=%0d last=%b"},
                             $time, expected_results[0].queue_id,
                             expected_results[0].data_symbol, expected_results[0].status,
                             expected_results[0].last, out_data.queue_id,
                             out_data.data_symbol, out_data.status, out_data.last);
                    void'(expected_results.pop_front());
                end
                else
                    void'(expected_results.pop_front());
            end
            if (hold_served != hold_requests && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_served++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic add_item(input logic [1:0] op, input logic [3:0] qn, input logic [7:0] sym);
        mqsb_in_t it;
        begin
            it.operation    = op;
            it.target_queue = qn;
            it.symbol       = sym;
            pending_items.push_back(it);
            items_issued++;
        end
    endtask

    task automatic add_random_items(input int count, input int push_pct);
        int lim;
        int roll;
        logic [1:0] op;
        logic [3:0] qn;
        begin
            lim = (int'(queues_limit) < QUEUES) ? int'(queues_limit) : QUEUES;
            repeat (count)
            begin
                roll = $urandom_range(0, 99);
                if (roll < push_pct)
                    op = OP_PUSH;
                else if (roll < push_pct + (100 - push_pct) / 2)
                    op = OP_POP;
                else if (roll < 94)
                    op = OP_DRAIN;
                else
                    op = OP_POP_ALT;
                if (lim == 0 || $urandom_range(0, 9) == 0)
                    qn = 4'($urandom_range(0, 15));
                else
                    qn = 4'($urandom_range(1, lim));
                add_item(op, qn, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic wait_drained;
        begin
            while (items_accepted != items_issued || expected_results.size() != 0)
                @(posedge clk);
            repeat (TAIL_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_queue_limit(input logic [3:0] value);
        begin
            @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_data  <= value;
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_valid    <= 1'b0;
            queues_limit = value;
        end
    endtask

    initial
    begin
        for (int q = 0; q < QUEUES; q++)
        begin
            head_copy[q] = 0;
            fill_copy[q] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, empty cases, spare opcode, invalid numbers, full queue
        add_item(OP_PUSH, 4'd8, 8'hFF);
        add_item(OP_PUSH, 4'd8, 8'h00);
        add_item(OP_POP, 4'd8, 8'h5A);
        add_item(OP_DRAIN, 4'd8, 8'h00);
        add_item(OP_POP, 4'd8, 8'hFF);
        add_item(OP_DRAIN, 4'd8, 8'hFF);
        add_item(OP_PUSH, 4'd1, SYM_A);
        add_item(OP_POP_ALT, 4'd1, 8'h00);
        add_item(OP_PUSH, 4'd0, 8'hA5);
        add_item(OP_DRAIN, 4'd15, 8'h3C);
        for (int i = 0; i <= DEPTH; i++)
            add_item(OP_PUSH, 4'd2, 8'(i * 37 + 11));
        add_item(OP_DRAIN, 4'd2, 8'h00);
        wait_drained();

        write_queue_limit(4'd0);
        add_random_items(20, 50);
        wait_drained();

        // limit above the bank size; receiver holds off to back up the input
        write_queue_limit(4'd15);
        add_random_items(120, 55);
        hold_requests++;
        wait_drained();

        write_queue_limit(4'd1);
        add_random_items(60, 80);
        wait_drained();

        no_idle = 1'b1;
        write_queue_limit(4'd3);
        add_random_items(100, 60);
        wait_drained();
        no_idle = 1'b0;

        write_queue_limit(4'd8);
        add_random_items(170, 55);
        wait_drained();

        if (expected_results.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results never arrived", $time, expected_results.size());
        end
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
design/mqsb_pkg.sv
design/mqsb_sym_ram.sv
design/mqsb_qtable.sv
design/mqsb_ctrl.sv
design/multi_queue_symbol_buffer.sv
design/mqsb_checker.sv
sim/testbench.sv
